>>> hdl/sfc_pkg.sv
// ============================================================================
// sfc_pkg
// Shared constants and types for the sfc32 random-range generator.
// ============================================================================
package sfc_pkg;

    localparam int unsigned WARMUP_STEPS = 15;
    localparam int unsigned WARM_W       = 4;

    localparam logic [31:0] INIT_A       = 32'h36ae_f51a;
    localparam logic [31:0] INIT_B       = 32'h21d4_b3eb;
    localparam logic [31:0] INIT_C       = 32'hf251_7abf;
    localparam logic [31:0] DEFAULT_SEED = 32'd352124;
    localparam logic [31:0] RAW_MASK     = 32'h7fff_ffff;

    localparam int unsigned RAW_W  = 31;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned SPAN_W = 33;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned FRAC_SHIFT = 31;

    // One draw from the generator as handed to the mapping pipeline.
    typedef struct packed {
        logic [RAW_W-1:0]  raw;
        logic [WORD_W-1:0] count;
    } sfc_draw_t;

    // Generator status seen by the top level.
    typedef struct packed {
        logic busy;
    } sfc_status_t;

endpackage

>>> hdl/sfc_core.sv
// ============================================================================
// sfc_core
// Generator state, seeding with warm-up, and one draw per accepted request.
// ============================================================================
module sfc_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    seed_write,
    input  logic [31:0]             seed_value,
    input  logic                    draw_take,
    output sfc_pkg::sfc_draw_t      draw,
    output sfc_pkg::sfc_status_t    status
);
    import sfc_pkg::*;

    logic [WORD_W-1:0] mix_a_reg, mix_a_next;
    logic [WORD_W-1:0] mix_b_reg, mix_b_next;
    logic [WORD_W-1:0] mix_c_reg, mix_c_next;
    logic [WORD_W-1:0] count_reg, count_next;
    logic [WARM_W-1:0] warm_reg, warm_next;

    logic [WORD_W-1:0] sum_t;
    logic [WORD_W-1:0] adv_a;
    logic [WORD_W-1:0] adv_b;
    logic [WORD_W-1:0] adv_c;
    logic [WORD_W-1:0] adv_count;
    logic              warming;

    assign warming   = (warm_reg != '0);
    assign sum_t     = mix_a_reg + mix_b_reg + count_reg;
    assign adv_count = count_reg + 32'd1;
    assign adv_a     = mix_b_reg ^ (mix_b_reg >> 9);
    assign adv_b     = mix_c_reg + (mix_c_reg << 3);
    assign adv_c     = {mix_c_reg[10:0], mix_c_reg[31:11]} + sum_t;

    always_comb
    begin
        mix_a_next = mix_a_reg;
        mix_b_next = mix_b_reg;
        mix_c_next = mix_c_reg;
        count_next = count_reg;
        warm_next  = warm_reg;
        if (seed_write)
        begin
            mix_a_next = INIT_A;
            mix_b_next = INIT_B;
            mix_c_next = INIT_C;
            count_next = seed_value;
            warm_next  = WARM_W'(WARMUP_STEPS);
        end
        else if (warming || draw_take)
        begin
            // Warm-up steps and real draws advance the state identically.
            mix_a_next = adv_a;
            mix_b_next = adv_b;
            mix_c_next = adv_c;
            count_next = adv_count;
            if (warming)
            begin
                warm_next = warm_reg - WARM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_a_reg <= INIT_A;
            mix_b_reg <= INIT_B;
            mix_c_reg <= INIT_C;
            count_reg <= DEFAULT_SEED;
            warm_reg  <= WARM_W'(WARMUP_STEPS);
        end
        else
        begin
            mix_a_reg <= mix_a_next;
            mix_b_reg <= mix_b_next;
            mix_c_reg <= mix_c_next;
            count_reg <= count_next;
            warm_reg  <= warm_next;
        end
    end

    assign draw.raw    = sum_t[RAW_W-1:0] & RAW_MASK[RAW_W-1:0];
    assign draw.count  = adv_count;
    assign status.busy = warming;

endmodule

>>> hdl/sfc_map.sv
// ============================================================================
// sfc_map
// Three-stage pipeline that scales a draw into the requested Q16.16 range.
// ============================================================================
module sfc_map (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    output logic                  take_ready,
    input  sfc_pkg::sfc_draw_t    draw,
    input  logic signed [31:0]    range_low,
    input  logic signed [31:0]    range_high,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [30:0]           raw_value,
    output logic signed [32:0]    mapped_value,
    output logic [31:0]           counter_now
);
    import sfc_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    logic [RAW_W-1:0]         raw1_reg, raw2_reg, raw3_reg;
    logic [WORD_W-1:0]        cnt1_reg, cnt2_reg, cnt3_reg;
    logic signed [WORD_W-1:0] lo1_reg, lo2_reg;
    logic signed [SPAN_W-1:0] span1_reg;
    logic signed [PROD_W-1:0] prod2_reg;
    logic signed [SPAN_W-1:0] map3_reg;

    logic signed [SPAN_W-1:0] span_next;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [SPAN_W-1:0] map_next;

    // Each stage moves on when the next one is empty or moving itself.
    assign rdy3       = !v3_reg || out_ready;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign take_ready = rdy1;

    assign span_next = SPAN_W'(range_high) - SPAN_W'(range_low);
    assign prod_next = PROD_W'(signed'({1'b0, raw1_reg})) * PROD_W'(span1_reg);
    // An arithmetic shift of the product floors towards minus infinity.
    assign map_next  = SPAN_W'(lo2_reg) + prod2_reg[PROD_W-1:FRAC_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= take;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && take)
        begin
            raw1_reg  <= draw.raw;
            cnt1_reg  <= draw.count;
            lo1_reg   <= range_low;
            span1_reg <= span_next;
        end
        if (rdy2 && v1_reg)
        begin
            raw2_reg  <= raw1_reg;
            cnt2_reg  <= cnt1_reg;
            lo2_reg   <= lo1_reg;
            prod2_reg <= prod_next;
        end
        if (rdy3 && v2_reg)
        begin
            raw3_reg <= raw2_reg;
            cnt3_reg <= cnt2_reg;
            map3_reg <= map_next;
        end
    end

    assign out_valid    = v3_reg;
    assign raw_value    = raw3_reg;
    assign counter_now  = cnt3_reg;
    assign mapped_value = map3_reg;

endmodule

>>> hdl/sfc32_random_range.sv
// ============================================================================
// sfc32_random_range
// sfc32 generator whose draws are mapped into a per-request Q16.16 range.
// ============================================================================
//  Channel  Direction  Handshake              Payload
//  cfg      in         cfg_valid/cfg_ready    seed_value
//  in       in         in_valid/in_ready      range_low, range_high
//  out      out        out_valid/out_ready    raw_value, mapped_value, counter_now
//
//  One request is accepted per cycle while in_ready is high; its result passes
//  the draw, multiply and add registers of the mapping pipeline in that order
//  before it is offered on the out channel.
//  After reset and after every seed write the generator runs its warm-up,
//  during which in_ready is low; cfg_ready is always high.
//  A stalled output holds its result while the earlier stages keep filling.
// ============================================================================
module sfc32_random_range (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [31:0] seed_value,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        raw_value,
    output logic signed [32:0] mapped_value,
    output logic signed [31:0] counter_now
);
    import sfc_pkg::*;

    sfc_draw_t   draw;
    sfc_status_t status;
    logic        seed_write;
    logic        take_ready;
    logic        take;
    logic [31:0] count_out;

    assign cfg_ready  = 1'b1;
    assign seed_write = cfg_valid && cfg_ready;
    assign in_ready   = take_ready && !status.busy;
    assign take       = in_valid && in_ready;

    sfc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_write (seed_write),
        .seed_value (seed_value),
        .draw_take  (take),
        .draw       (draw),
        .status     (status)
    );

    sfc_map u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .take_ready   (take_ready),
        .draw         (draw),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .raw_value    (raw_value),
        .mapped_value (mapped_value),
        .counter_now  (count_out)
    );

    assign counter_now = signed'(count_out);

    // A seed write always starts a warm-up, so no request can follow at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_write |=> !in_ready)
        else $error("request accepted straight after a seed write");

    // Each accepted request advances the counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !seed_write) |=> (draw.count == $past(draw.count) + 32'd1))
        else $error("counter did not advance by one on a request");

    // The counter does not move while nothing is accepted and no warm-up runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!take && !seed_write && !status.busy) |=> $stable(draw.count))
        else $error("counter moved without a request");

endmodule

>>> tb/tb.sv
// ============================================================================
// tb
// Self-checking bench for the sfc32 random-range generator. A behavioural
// copy of the generator predicts the raw draw, the counter and the Q16.16
// mapped value of every accepted range request. A checker process compares
// each delivered result with the oldest prediction. Directed requests cover
// extreme and reversed bounds and extreme seeds. Random phases then run with
// reseeding, random idling on both channels and one long output hold-off.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 20;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned PHASE_REQUESTS  = 215;

    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    typedef struct {
        logic [30:0]        raw;
        logic signed [32:0] mapped;
        logic [31:0]        count;
    } range_result_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic signed [31:0] seed_value = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic signed [31:0] range_low  = '0;
    logic signed [31:0] range_high = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [30:0]        raw_value;
    logic signed [32:0] mapped_value;
    logic signed [31:0] counter_now;

    // Behavioural copy of the generator state.
    logic [31:0] gen_a;
    logic [31:0] gen_b;
    logic [31:0] gen_c;
    logic [31:0] gen_count;

    range_result_t pending_results[$];

    bit          gaps_on         = 1'b1;
    bit          hold_off_toggle = 1'b0;
    bit          hold_off_seen   = 1'b0;
    int unsigned hold_off_left   = 0;
    int unsigned error_count     = 0;
    int unsigned missing_count   = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent   = 0;
    int unsigned seeds_written   = 0;
    int unsigned cycle_count     = 0;

    sfc32_random_range dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .seed_value   (seed_value),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .raw_value    (raw_value),
        .mapped_value (mapped_value),
        .counter_now  (counter_now)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------------
    task automatic advance_generator(output logic [30:0] raw);
        logic [31:0] t;
        t         = gen_a + gen_b + gen_count;
        gen_count = gen_count + 32'd1;
        gen_a     = gen_b ^ (gen_b >> 9);
        gen_b     = gen_c + (gen_c << 3);
        gen_c     = {gen_c[10:0], gen_c[31:11]} + t;
        raw       = t[30:0];
    endtask

    task automatic reseed_generator(input logic [31:0] seed);
        logic [30:0] discard;
        gen_count = seed;
        gen_a     = INIT_A;
        gen_b     = INIT_B;
        gen_c     = INIT_C;
        repeat (WARMUP_STEPS) advance_generator(discard);
    endtask

    // The arithmetic shift floors towards minus infinity, as a reversed range
    // with its negative span requires.
    function automatic logic signed [32:0] map_into_range(input logic [30:0] raw,
                                                          input logic signed [31:0] lo,
                                                          input logic signed [31:0] hi);
        logic signed [63:0] raw_ext;
        logic signed [63:0] span;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        raw_ext = $signed({33'd0, raw});
        span    = 64'(hi) - 64'(lo);
        prod    = raw_ext * span;
        sum     = 64'(lo) + (prod >>> 31);
        return sum[32:0];
    endfunction

    task automatic predict_result(input logic signed [31:0] lo,
                                  input logic signed [31:0] hi);
        range_result_t item;
        logic [30:0]   raw;
        advance_generator(raw);
        item.raw    = raw;
        item.mapped = map_into_range(raw, lo, hi);
        item.count  = gen_count;
        pending_results.push_back(item);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] random_bound();
        logic signed [31:0] value;
        case ($urandom_range(0, 5))
            3: begin
                case ($urandom_range(0, 3))
                    0: value = Q_MIN;
                    1: value = Q_MAX;
                    2: value = '0;
                    default: value = -32'sd1;
                endcase
            end
            4: value = $signed($urandom_range(0, 200 << 16)) - (100 <<< 16);
            default: value = $signed($urandom());
        endcase
        return value;
    endfunction

    // Valid is only lowered when the sender idles, so a back-to-back request
    // never sees valid dropped and raised within one step.
    task automatic send_range(input logic signed [31:0] lo,
                              input logic signed [31:0] hi);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 24) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        predict_result(lo, hi);
        requests_sent++;
    endtask

    task automatic send_random_range();
        logic signed [31:0] lo;
        lo = random_bound();
        if ($urandom_range(0, 11) == 0)
            send_range(lo, lo);
        else
            send_range(lo, random_bound());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Only called with the block idle: no request offered, nothing pending.
    task automatic write_seed(input logic signed [31:0] seed);
        cfg_valid  <= 1'b1;
        seed_value <= seed;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        reseed_generator(seed);
        seeds_written++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("tb: unexpected result raw=%h mapped=%h count=%h",
                             raw_value, mapped_value, counter_now);
            end else begin
                range_result_t want;
                want = pending_results.pop_front();
                results_checked++;
                if (raw_value !== want.raw || mapped_value !== want.mapped ||
                    counter_now !== want.count) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"tb: mismatch on result %0d: raw %h/%h, ",
                                  "mapped %h/%h, count %h/%h (expected/actual)"},
                                 results_checked, want.raw, raw_value,
                                 want.mapped, mapped_value, want.count, counter_now);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output-side flow control, with the long hold-off counted here
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_off_toggle != hold_off_seen) begin
            hold_off_seen = hold_off_toggle;
            hold_off_left = HOLD_OFF_CYCLES;
        end

        if (hold_off_left != 0) begin
            hold_off_left--;
            out_ready <= 1'b0;
        end else if (gaps_on)
            out_ready <= ($urandom_range(0, 99) >= 24);
        else
            out_ready <= 1'b1;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: no progress within %0d cycles", CYCLE_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_bounds();
        send_range('0, '0);
        send_range(Q_MIN, Q_MAX);
        send_range(Q_MAX, Q_MIN);
        send_range(-32'sd1, '0);
        send_range(Q_MAX, Q_MAX);
        send_range(Q_MIN, Q_MIN);
        send_range(-5 * Q_ONE, 5 * Q_ONE);
        send_range('0, Q_ONE);
        drain_results();
    endtask

    task automatic test_seed_extremes();
        logic signed [31:0] seeds[5];
        // The last seed leaves the counter at all ones after warm-up, so the
        // first draw wraps it.
        seeds = '{-32'sd1, Q_MIN, Q_MAX, 32'sd0, 32'shffff_fff0};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_random_range();
            send_random_range();
            drain_results();
        end
    endtask

    task automatic test_random_ranges();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1)
                write_seed(DEFAULT_SEED);
            else
                write_seed($signed($urandom()));
            repeat (PHASE_REQUESTS) send_random_range();
            drain_results();
        end
    endtask

    task automatic test_full_speed();
        gaps_on = 1'b0;
        repeat (100) send_random_range();
        drain_results();
        gaps_on = 1'b1;
    endtask

    // The receiver stalls on its own while requests keep coming, so the
    // pipeline fills and in_ready must drop.
    task automatic test_output_hold_off();
        gaps_on = 1'b0;
        hold_off_toggle = ~hold_off_toggle;
        repeat (40) send_random_range();
        drain_results();
        gaps_on = 1'b1;
    endtask

    initial begin
        reseed_generator(DEFAULT_SEED);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_bounds();
        test_seed_extremes();
        test_random_ranges();
        test_full_speed();
        test_output_hold_off();

        repeat (SETTLE_CYCLES) @(posedge clk);
        missing_count = pending_results.size();
        if (missing_count != 0)
            $display("tb: %0d predicted results never arrived", missing_count);

        $display("tb: %0d range requests sent, %0d results checked, %0d seed writes",
                 requests_sent, results_checked, seeds_written);
        $display("tb: covered extreme, equal and reversed bounds, counter wrap, output stall");
        if (error_count == 0 && missing_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
